@@ rtl/dets_pkg.sv @@
// Shared constants, command codes and the controller-to-datapath command type.
`timescale 1ns / 1ps

package dets_pkg;

  // Default widths of samples and of poles and gains.
  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_COEFF_WIDTH  = 16;

  // Envelope levels are held with full scale at bit 31.
  localparam int LEVEL_WIDTH = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_WIDTH = 3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FAST_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FAST_RELEASE = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SLOW_ATTACK  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SLOW_RELEASE = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SMOOTHING    = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SENSITIVITY  = 3'd5;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_FAST_OLD,
    MUL_FAST_X,
    MUL_SLOW_OLD,
    MUL_SLOW_X,
    MUL_DIFF,
    MUL_GAIN_OLD,
    MUL_GAIN_RAW,
    MUL_L_G,
    MUL_R_G,
    MUL_L_NG,
    MUL_R_NG
  } mul_sel_e;

  // Accumulator operation on the registered product.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_HALF,
    ACC_ADD
  } acc_op_e;

  // Register that captures a result taken from the accumulator.
  typedef enum logic [3:0] {
    STO_NONE,
    STO_FAST,
    STO_SLOW,
    STO_RAW,
    STO_GAIN,
    STO_TL,
    STO_TR,
    STO_BL,
    STO_BR
  } store_sel_e;

  // One cycle's worth of datapath control.
  typedef struct packed {
    logic       load_in;
    mul_sel_e   mul_sel;
    acc_op_e    acc_op;
    store_sel_e store_sel;
    logic       load_out;
  } dets_cmd_t;

endpackage

@@ rtl/dets_ctrl.sv @@
// Sequencing state machine that steps the shared multiplier through one request.
`timescale 1ns / 1ps

module dets_ctrl
  import dets_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dets_cmd_t cmd_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_S1   = 5'd1;
  localparam logic [4:0] ST_S2   = 5'd2;
  localparam logic [4:0] ST_S3   = 5'd3;
  localparam logic [4:0] ST_S4   = 5'd4;
  localparam logic [4:0] ST_S5   = 5'd5;
  localparam logic [4:0] ST_S6   = 5'd6;
  localparam logic [4:0] ST_S7   = 5'd7;
  localparam logic [4:0] ST_S8   = 5'd8;
  localparam logic [4:0] ST_S9   = 5'd9;
  localparam logic [4:0] ST_S10  = 5'd10;
  localparam logic [4:0] ST_S11  = 5'd11;
  localparam logic [4:0] ST_S12  = 5'd12;
  localparam logic [4:0] ST_S13  = 5'd13;
  localparam logic [4:0] ST_S14  = 5'd14;
  localparam logic [4:0] ST_S15  = 5'd15;
  localparam logic [4:0] ST_S16  = 5'd16;
  localparam logic [4:0] ST_S17  = 5'd17;
  localparam logic [4:0] ST_S18  = 5'd18;
  localparam logic [4:0] ST_DONE = 5'd19;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Step decode: multiplier operands, accumulator action and result capture.
  always_comb begin
    state_d         = state_q;
    cmd_o.load_in   = 1'b0;
    cmd_o.mul_sel   = MUL_NONE;
    cmd_o.acc_op    = ACC_HOLD;
    cmd_o.store_sel = STO_NONE;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_S1;
        end
      end
      ST_S1: begin
        cmd_o.mul_sel = MUL_FAST_OLD;
        state_d       = ST_S2;
      end
      ST_S2: begin
        cmd_o.mul_sel = MUL_FAST_X;
        cmd_o.acc_op  = ACC_LOAD_HALF;
        state_d       = ST_S3;
      end
      ST_S3: begin
        cmd_o.mul_sel = MUL_SLOW_OLD;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_S4;
      end
      ST_S4: begin
        cmd_o.mul_sel   = MUL_SLOW_X;
        cmd_o.acc_op    = ACC_LOAD_HALF;
        cmd_o.store_sel = STO_FAST;
        state_d         = ST_S5;
      end
      ST_S5: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_S6;
      end
      ST_S6: begin
        cmd_o.store_sel = STO_SLOW;
        state_d         = ST_S7;
      end
      ST_S7: begin
        cmd_o.mul_sel = MUL_DIFF;
        state_d       = ST_S8;
      end
      ST_S8: begin
        cmd_o.acc_op = ACC_LOAD;
        state_d      = ST_S9;
      end
      ST_S9: begin
        cmd_o.mul_sel   = MUL_GAIN_OLD;
        cmd_o.store_sel = STO_RAW;
        state_d         = ST_S10;
      end
      ST_S10: begin
        cmd_o.mul_sel = MUL_GAIN_RAW;
        cmd_o.acc_op  = ACC_LOAD_HALF;
        state_d       = ST_S11;
      end
      ST_S11: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_S12;
      end
      ST_S12: begin
        cmd_o.store_sel = STO_GAIN;
        state_d         = ST_S13;
      end
      ST_S13: begin
        cmd_o.mul_sel = MUL_L_G;
        state_d       = ST_S14;
      end
      ST_S14: begin
        cmd_o.mul_sel = MUL_R_G;
        cmd_o.acc_op  = ACC_LOAD_HALF;
        state_d       = ST_S15;
      end
      ST_S15: begin
        cmd_o.mul_sel   = MUL_L_NG;
        cmd_o.acc_op    = ACC_LOAD_HALF;
        cmd_o.store_sel = STO_TL;
        state_d         = ST_S16;
      end
      ST_S16: begin
        cmd_o.mul_sel   = MUL_R_NG;
        cmd_o.acc_op    = ACC_LOAD_HALF;
        cmd_o.store_sel = STO_TR;
        state_d         = ST_S17;
      end
      ST_S17: begin
        cmd_o.acc_op    = ACC_LOAD_HALF;
        cmd_o.store_sel = STO_BL;
        state_d         = ST_S18;
      end
      ST_S18: begin
        cmd_o.store_sel = STO_BR;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        // Hand over once the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/dets_datapath.sv @@
// Datapath: registers, envelope state, shared multiplier and accumulator.
`timescale 1ns / 1ps

module dets_datapath
  import dets_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEFF_WIDTH  = DEF_COEFF_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dets_cmd_t                      cmd_i,
  input  logic                           cfg_valid_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [COEFF_WIDTH-1:0]         cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] texture_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] texture_right_o,
  output logic signed [SAMPLE_WIDTH-1:0] body_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] body_right_o,
  output logic [COEFF_WIDTH:0]           texture_gain_o
);

  localparam int SG_W  = COEFF_WIDTH + 3;
  localparam int MA_W  = LEVEL_WIDTH + 1;
  localparam int P_W   = MA_W + SG_W + 1;
  localparam int ACC_W = P_W + 1;
  localparam int RAW_W = ACC_W - (LEVEL_WIDTH - 1);
  localparam int GF_W  = ACC_W - COEFF_WIDTH;

  localparam logic [COEFF_WIDTH:0]    ONE_Q  = (COEFF_WIDTH + 1)'(1) << COEFF_WIDTH;
  localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(1) << (COEFF_WIDTH - 1);

  // Configuration registers.
  logic [COEFF_WIDTH-1:0] fa_q, fr_q, sa_q, sr_q, sc_q, sens_q;

  // Item registers and envelope state.
  logic signed [SAMPLE_WIDTH-1:0] l_q, r_q;
  logic [LEVEL_WIDTH-1:0]         x_q, x_d;
  logic [LEVEL_WIDTH-1:0]         fast_q, slow_q;
  logic [COEFF_WIDTH:0]           gain_q, raw_q;
  logic [SAMPLE_WIDTH-1:0]        tl_q, tr_q, bl_q, br_q;

  // Multiplier and accumulator.
  logic [MA_W-1:0]          mul_a;
  logic [SG_W-1:0]          mul_b;
  logic signed [P_W-1:0]    prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  // Derived operands.
  logic signed [SAMPLE_WIDTH:0] sum_w;
  logic [SAMPLE_WIDTH:0]        mag_w;
  logic [LEVEL_WIDTH:0]         x_ext;
  logic [COEFF_WIDTH-1:0]       fast_pole, slow_pole;
  logic [COEFF_WIDTH:0]         fast_npole, slow_npole, sc_n, gain_n;
  logic [LEVEL_WIDTH-1:0]       diff;
  logic [SG_W-1:0]              sg;
  logic [RAW_W-1:0]             raw_full;
  logic [COEFF_WIDTH:0]         raw_sat;
  logic [GF_W-1:0]              gain_full;
  logic [COEFF_WIDTH:0]         gain_sat;

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q   <= '1;
      fr_q   <= '1;
      sa_q   <= '1;
      sr_q   <= '1;
      sc_q   <= '1;
      sens_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FAST_ATTACK:  fa_q   <= cfg_data_i;
        REG_FAST_RELEASE: fr_q   <= cfg_data_i;
        REG_SLOW_ATTACK:  sa_q   <= cfg_data_i;
        REG_SLOW_RELEASE: sr_q   <= cfg_data_i;
        REG_SMOOTHING:    sc_q   <= cfg_data_i;
        REG_SENSITIVITY:  sens_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Mono magnitude scaled so that full scale sits at bit 31.
  always_comb begin
    sum_w = {left_sample_i[SAMPLE_WIDTH-1], left_sample_i}
          + {right_sample_i[SAMPLE_WIDTH-1], right_sample_i};
    mag_w = sum_w[SAMPLE_WIDTH] ? -sum_w : sum_w;
    x_ext = (LEVEL_WIDTH + 1)'(mag_w) << (LEVEL_WIDTH - SAMPLE_WIDTH);
    x_d   = x_ext[LEVEL_WIDTH:1];
  end

  // Pole choice, complements, level difference and sensitivity scale.
  always_comb begin
    fast_pole  = (x_q > fast_q) ? fa_q : fr_q;
    slow_pole  = (x_q > slow_q) ? sa_q : sr_q;
    fast_npole = ONE_Q - {1'b0, fast_pole};
    slow_npole = ONE_Q - {1'b0, slow_pole};
    sc_n       = ONE_Q - {1'b0, sc_q};
    gain_n     = ONE_Q - gain_q;
    diff       = (fast_q > slow_q) ? (fast_q - slow_q) : '0;
    sg         = SG_W'(ONE_Q) + (SG_W'(sens_q) << 3) - SG_W'(sens_q);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_FAST_OLD: begin
        mul_a = {1'b0, fast_q};
        mul_b = SG_W'(fast_pole);
      end
      MUL_FAST_X: begin
        mul_a = {1'b0, x_q};
        mul_b = SG_W'(fast_npole);
      end
      MUL_SLOW_OLD: begin
        mul_a = {1'b0, slow_q};
        mul_b = SG_W'(slow_pole);
      end
      MUL_SLOW_X: begin
        mul_a = {1'b0, x_q};
        mul_b = SG_W'(slow_npole);
      end
      MUL_DIFF: begin
        mul_a = {1'b0, diff};
        mul_b = sg;
      end
      MUL_GAIN_OLD: begin
        mul_a = MA_W'(gain_q);
        mul_b = SG_W'(sc_q);
      end
      MUL_GAIN_RAW: begin
        mul_a = MA_W'(raw_q);
        mul_b = SG_W'(sc_n);
      end
      MUL_L_G: begin
        mul_a = {{(MA_W - SAMPLE_WIDTH){l_q[SAMPLE_WIDTH-1]}}, l_q};
        mul_b = SG_W'(gain_q);
      end
      MUL_R_G: begin
        mul_a = {{(MA_W - SAMPLE_WIDTH){r_q[SAMPLE_WIDTH-1]}}, r_q};
        mul_b = SG_W'(gain_q);
      end
      MUL_L_NG: begin
        mul_a = {{(MA_W - SAMPLE_WIDTH){l_q[SAMPLE_WIDTH-1]}}, l_q};
        mul_b = SG_W'(gain_n);
      end
      MUL_R_NG: begin
        mul_a = {{(MA_W - SAMPLE_WIDTH){r_q[SAMPLE_WIDTH-1]}}, r_q};
        mul_b = SG_W'(gain_n);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = $signed(mul_a) * $signed({1'b0, mul_b});
  end

  // Accumulator update from the product of the previous cycle.
  always_comb begin
    acc_d = acc_q;
    case (cmd_i.acc_op)
      ACC_LOAD:      acc_d = ACC_W'(prod_q);
      ACC_LOAD_HALF: acc_d = ACC_W'(prod_q) + HALF_Q;
      ACC_ADD:       acc_d = acc_q + ACC_W'(prod_q);
      default:       acc_d = acc_q;
    endcase
  end

  // Raw gain and smoothed gain, each saturated to one.
  always_comb begin
    raw_full  = acc_q[ACC_W-1:LEVEL_WIDTH-1];
    raw_sat   = (raw_full > RAW_W'(ONE_Q)) ? ONE_Q : raw_full[COEFF_WIDTH:0];
    gain_full = acc_q[ACC_W-1:COEFF_WIDTH];
    gain_sat  = (gain_full > GF_W'(ONE_Q)) ? ONE_Q : gain_full[COEFF_WIDTH:0];
  end

  // Envelope and gain state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
      gain_q <= '0;
    end else begin
      case (cmd_i.store_sel)
        STO_FAST: fast_q <= acc_q[COEFF_WIDTH+LEVEL_WIDTH-1:COEFF_WIDTH];
        STO_SLOW: slow_q <= acc_q[COEFF_WIDTH+LEVEL_WIDTH-1:COEFF_WIDTH];
        STO_GAIN: gain_q <= gain_sat;
        default: ;
      endcase
    end
  end

  // Item payload, product, accumulator and scaled results.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.load_in) begin
      l_q <= left_sample_i;
      r_q <= right_sample_i;
      x_q <= x_d;
    end
    case (cmd_i.store_sel)
      STO_RAW: raw_q <= raw_sat;
      STO_TL:  tl_q  <= acc_q[COEFF_WIDTH+SAMPLE_WIDTH-1:COEFF_WIDTH];
      STO_TR:  tr_q  <= acc_q[COEFF_WIDTH+SAMPLE_WIDTH-1:COEFF_WIDTH];
      STO_BL:  bl_q  <= acc_q[COEFF_WIDTH+SAMPLE_WIDTH-1:COEFF_WIDTH];
      STO_BR:  br_q  <= acc_q[COEFF_WIDTH+SAMPLE_WIDTH-1:COEFF_WIDTH];
      default: ;
    endcase
    if (cmd_i.load_out) begin
      texture_left_o  <= tl_q;
      texture_right_o <= tr_q;
      body_left_o     <= bl_q;
      body_right_o    <= br_q;
      texture_gain_o  <= gain_q;
    end
  end

endmodule

@@ rtl/dual_envelope_transient_splitter_top.sv @@
// Requests are taken only while the sequencer is idle; it works on one request at a time
// and waits on an output stall before it hands the result over. The single shared multiplier
// carries eleven products per request through one accumulator.
// The output register holds a finished result while the next request is taken.
// Reset (rst_ni low, asynchronous) clears both envelopes and the smoothed gain,
// sets the five poles to all ones and the sensitivity to zero.
`timescale 1ns / 1ps

module dual_envelope_transient_splitter_top
  import dets_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEFF_WIDTH  = DEF_COEFF_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [COEFF_WIDTH-1:0]         cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] texture_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] texture_right_o,
  output logic signed [SAMPLE_WIDTH-1:0] body_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] body_right_o,
  output logic [COEFF_WIDTH:0]           texture_gain_o
);

  dets_cmd_t cmd;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Step sequencer.
  dets_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  dets_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEFF_WIDTH  (COEFF_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .texture_left_o  (texture_left_o),
    .texture_right_o (texture_right_o),
    .body_left_o     (body_left_o),
    .body_right_o    (body_right_o),
    .texture_gain_o  (texture_gain_o)
  );

`ifndef SYNTH
  // A taken request keeps the input closed while it is worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while a request is in progress");

  // A new result appears only at the end of a request's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result presented without a request being processed");

  // The presented gain never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> texture_gain_o <= ((COEFF_WIDTH + 1)'(1) << COEFF_WIDTH))
    else $error("texture gain above unity");
`endif

endmodule

@@ sim/tb_dual_envelope_transient_splitter_top.sv @@
// Testbench for the dual envelope transient splitter: directed table, random transients, checked against a predictor.
`timescale 1ns / 1ps

module tb_dual_envelope_transient_splitter_top;
  import dets_pkg::*;

  localparam int SW          = DEF_SAMPLE_WIDTH;
  localparam int CW          = DEF_COEFF_WIDTH;
  localparam int LATENCY     = 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

  typedef longint unsigned u64_t;

  localparam u64_t ONE_Q  = u64_t'(1) << CW;
  localparam u64_t HALF_Q = ONE_Q >> 1;

  localparam logic [CW-1:0]        COEFF_ZERO = '0;
  localparam logic [CW-1:0]        COEFF_MAX  = '1;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW:0]          GAIN_ONE   = {1'b1, {CW{1'b0}}};

  // One result item as the block returns it.
  typedef struct packed {
    logic signed [SW-1:0] tl;
    logic signed [SW-1:0] tr;
    logic signed [SW-1:0] bl;
    logic signed [SW-1:0] br;
    logic [CW:0]          g;
  } split_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICTED,
    ROW_KNOWN
  } row_kind_e;

  // One line of the directed stimulus.
  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_WIDTH-1:0] idx;
    logic [CW-1:0]            data;
    logic signed [SW-1:0]     l;
    logic signed [SW-1:0]     r;
    split_t                   want;
  } row_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_valid_i     = 1'b0;
  logic                           cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i     = '0;
  logic [CW-1:0]                  cfg_data_i      = '0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_ready_o;
  logic signed [SW-1:0]           left_sample_i   = '0;
  logic signed [SW-1:0]           right_sample_i  = '0;
  logic                           out_valid_o;
  logic                           out_ready_i     = 1'b0;
  logic signed [SW-1:0]           texture_left_o;
  logic signed [SW-1:0]           texture_right_o;
  logic signed [SW-1:0]           body_left_o;
  logic signed [SW-1:0]           body_right_o;
  logic [CW:0]                    texture_gain_o;

  // Predictor state: both envelopes, the smoothed gain and the register file.
  logic [31:0]   fast_env;
  logic [31:0]   slow_env;
  logic [CW:0]   gain_env;
  logic [CW-1:0] reg_file [0:5];

  split_t expected_splits [$];
  row_t   directed_rows [$];

  bit steady = 1'b0;
  int mismatches      = 0;
  int results_checked = 0;
  int pairs_sent      = 0;
  int reg_writes      = 0;
  int gain_full       = 0;
  int gain_zero       = 0;
  int cycle_count     = 0;

  dual_envelope_transient_splitter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .texture_left_o  (texture_left_o),
    .texture_right_o (texture_right_o),
    .body_left_o     (body_left_o),
    .body_right_o    (body_right_o),
    .texture_gain_o  (texture_gain_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One-pole step with rounding: pole weights the old value, ONE - pole the target.
  function automatic u64_t pole_step(input u64_t pole, input u64_t old_v, input u64_t target);
    return (pole * old_v + (ONE_Q - pole) * target + HALF_Q) >> CW;
  endfunction

  // Attack pole while the level is strictly above the envelope, release otherwise.
  function automatic u64_t follow_level(input u64_t env, input u64_t lvl,
                                        input u64_t att, input u64_t rel);
    return pole_step((lvl > env) ? att : rel, env, lvl);
  endfunction

  // Sample times gain in Q1.16, rounded half up, wrapped to the sample width.
  function automatic logic signed [SW-1:0] scale_sample(input logic signed [SW-1:0] s,
                                                       input u64_t g);
    longint p;
    p = longint'(s) * longint'(g) + longint'(HALF_Q);
    return p[CW+SW-1:CW];
  endfunction

  // Advances the predictor by one stereo pair and returns the split it yields.
  function automatic split_t split_sample(input logic signed [SW-1:0] l,
                                          input logic signed [SW-1:0] r);
    longint sum;
    u64_t   lvl;
    u64_t   diff;
    u64_t   raw;
    u64_t   g;
    split_t res;
    sum = longint'(l) + longint'(r);
    lvl = u64_t'((sum < 0) ? -sum : sum);
    lvl = (lvl << (32 - SW)) >> 1;
    fast_env = 32'(follow_level(u64_t'(fast_env), lvl, u64_t'(reg_file[REG_FAST_ATTACK]),
                                u64_t'(reg_file[REG_FAST_RELEASE])));
    slow_env = 32'(follow_level(u64_t'(slow_env), lvl, u64_t'(reg_file[REG_SLOW_ATTACK]),
                                u64_t'(reg_file[REG_SLOW_RELEASE])));
    raw = 0;
    if (fast_env > slow_env) begin
      diff = u64_t'(fast_env) - u64_t'(slow_env);
      raw  = (diff * (ONE_Q + u64_t'(7) * u64_t'(reg_file[REG_SENSITIVITY]))) >> 31;
      if (raw > ONE_Q) begin
        raw = ONE_Q;
      end
    end
    g = pole_step(u64_t'(reg_file[REG_SMOOTHING]), u64_t'(gain_env), raw);
    if (g > ONE_Q) begin
      g = ONE_Q;
    end
    gain_env = g[CW:0];
    res.tl = scale_sample(l, g);
    res.tr = scale_sample(r, g);
    res.bl = scale_sample(l, ONE_Q - g);
    res.br = scale_sample(r, ONE_Q - g);
    res.g  = g[CW:0];
    return res;
  endfunction

  function automatic row_t write_row(input logic [CFG_IDX_WIDTH-1:0] idx,
                                     input logic [CW-1:0] data);
    row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic row_t pair_row(input logic signed [SW-1:0] l,
                                    input logic signed [SW-1:0] r);
    row_t row;
    row      = '0;
    row.kind = ROW_PREDICTED;
    row.l    = l;
    row.r    = r;
    return row;
  endfunction

  function automatic row_t known_row(input logic signed [SW-1:0] l,
                                     input logic signed [SW-1:0] r,
                                     input logic signed [SW-1:0] tl,
                                     input logic signed [SW-1:0] tr,
                                     input logic signed [SW-1:0] bl,
                                     input logic signed [SW-1:0] br,
                                     input logic [CW:0] g);
    row_t row;
    row         = pair_row(l, r);
    row.kind    = ROW_KNOWN;
    row.want.tl = tl;
    row.want.tr = tr;
    row.want.bl = bl;
    row.want.br = br;
    row.want.g  = g;
    return row;
  endfunction

  // Sample drawn around the current amplitude, with the odd full-range or extreme value.
  function automatic logic signed [SW-1:0] draw_sample(input int amp);
    logic signed [SW-1:0] s;
    case ($urandom_range(0, 9))
      0: s = SW'($urandom());
      1: begin
        case ($urandom_range(0, 4))
          0:       s = SAMPLE_MAX;
          1:       s = SAMPLE_MIN;
          2:       s = '0;
          3:       s = -24'sd1;
          default: s = 24'sd1;
        endcase
      end
      default: s = SW'(int'($urandom_range(0, 2 * amp)) - amp);
    endcase
    return s;
  endfunction

  // Drops the input request, then waits until every result is back and the block is quiet.
  task automatic settle_idle();
    in_valid_i = 1'b0;
    while (expected_splits.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_SENSITIVITY) begin
      reg_file[idx] = data;
    end
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Presents one stereo request after a random gap, none while the run is steady; valid stays high afterwards.
  task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                           input bit known, input split_t typed);
    int     gap;
    split_t predicted;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    left_sample_i  = l;
    right_sample_i = r;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = split_sample(l, r);
    expected_splits.push_back(known ? typed : predicted);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_setting(input logic [CW-1:0] fa, input logic [CW-1:0] fr,
                              input logic [CW-1:0] sa, input logic [CW-1:0] sr,
                              input logic [CW-1:0] sm, input logic [CW-1:0] se);
    settle_idle();
    write_reg(REG_FAST_ATTACK, fa);
    write_reg(REG_FAST_RELEASE, fr);
    write_reg(REG_SLOW_ATTACK, sa);
    write_reg(REG_SLOW_RELEASE, sr);
    write_reg(REG_SMOOTHING, sm);
    write_reg(REG_SENSITIVITY, se);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Output side: a random stall before each result, none while the run is steady.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compares each accepted result with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    split_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_splits.size() == 0) begin
        $error("result with no request outstanding, texture_gain %0d", texture_gain_o);
        mismatches++;
      end else begin
        want = expected_splits.pop_front();
        check_field("texture_left", longint'(signed'(want.tl)), longint'(texture_left_o));
        check_field("texture_right", longint'(signed'(want.tr)), longint'(texture_right_o));
        check_field("body_left", longint'(signed'(want.bl)), longint'(body_left_o));
        check_field("body_right", longint'(signed'(want.br)), longint'(body_right_o));
        check_field("texture_gain", longint'(want.g), longint'(texture_gain_o));
        results_checked++;
        if (want.g == GAIN_ONE) begin
          gain_full++;
        end else if (want.g == '0) begin
          gain_zero++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL dual_envelope_transient_splitter_top");
    $finish;
  end

  initial begin
    row_t                 row;
    int                   amp;
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] r;
    logic [CW-1:0]        fa;
    logic [CW-1:0]        fr;
    logic [CW-1:0]        sa;
    logic [CW-1:0]        sr;
    logic [CW-1:0]        sm;
    logic [CW-1:0]        se;

    fast_env = '0;
    slow_env = '0;
    gain_env = '0;
    reg_file[REG_FAST_ATTACK]  = COEFF_MAX;
    reg_file[REG_FAST_RELEASE] = COEFF_MAX;
    reg_file[REG_SLOW_ATTACK]  = COEFF_MAX;
    reg_file[REG_SLOW_RELEASE] = COEFF_MAX;
    reg_file[REG_SMOOTHING]    = COEFF_MAX;
    reg_file[REG_SENSITIVITY]  = COEFF_ZERO;

    // Straight after reset the gain stays at zero, so body passes the samples through.
    directed_rows.push_back(known_row('0, '0, '0, '0, '0, '0, '0));
    directed_rows.push_back(known_row(SAMPLE_MAX, SAMPLE_MIN, '0, '0, SAMPLE_MAX, SAMPLE_MIN,
                                      '0));
    // Fast follower tracks the input, slow one barely moves: full-scale input saturates g.
    directed_rows.push_back(write_row(REG_FAST_ATTACK, COEFF_ZERO));
    directed_rows.push_back(write_row(REG_FAST_RELEASE, COEFF_ZERO));
    directed_rows.push_back(write_row(REG_SLOW_ATTACK, COEFF_MAX));
    directed_rows.push_back(write_row(REG_SLOW_RELEASE, COEFF_MAX));
    directed_rows.push_back(write_row(REG_SMOOTHING, COEFF_ZERO));
    directed_rows.push_back(write_row(REG_SENSITIVITY, COEFF_MAX));
    directed_rows.push_back(known_row('0, '0, '0, '0, '0, '0, '0));
    directed_rows.push_back(known_row(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, '0,
                                      GAIN_ONE));
    directed_rows.push_back(known_row(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, '0, '0,
                                      GAIN_ONE));
    directed_rows.push_back(known_row('0, '0, '0, '0, '0, '0, '0));
    directed_rows.push_back(pair_row(24'sd1, '0));
    directed_rows.push_back(pair_row(-24'sd1, '0));
    directed_rows.push_back(pair_row(SAMPLE_MAX, SAMPLE_MIN));
    directed_rows.push_back(pair_row(24'sd4194304, SAMPLE_MIN));
    // Mid-range poles with smoothing and no sensitivity boost.
    directed_rows.push_back(write_row(REG_SLOW_ATTACK, 16'd61440));
    directed_rows.push_back(write_row(REG_SLOW_RELEASE, 16'd64000));
    directed_rows.push_back(write_row(REG_SMOOTHING, 16'd49152));
    directed_rows.push_back(write_row(REG_SENSITIVITY, COEFF_ZERO));
    directed_rows.push_back(pair_row(SAMPLE_MAX, SAMPLE_MAX));
    directed_rows.push_back(pair_row(SAMPLE_MIN, '0));
    directed_rows.push_back(pair_row(24'sd123456, -24'sd654321));
    directed_rows.push_back(pair_row('0, '0));
    // Writes beyond the register file must leave every setting as it was.
    directed_rows.push_back(write_row(REG_SPARE_LO, COEFF_MAX));
    directed_rows.push_back(write_row(REG_SPARE_HI, COEFF_ZERO));
    directed_rows.push_back(pair_row(SAMPLE_MAX, SAMPLE_MAX));
    directed_rows.push_back(pair_row(-24'sd3000000, 24'sd2000000));
    // Slowest fast follower with half sensitivity.
    directed_rows.push_back(write_row(REG_FAST_ATTACK, COEFF_MAX));
    directed_rows.push_back(write_row(REG_FAST_RELEASE, COEFF_MAX));
    directed_rows.push_back(write_row(REG_SENSITIVITY, 16'd32768));
    directed_rows.push_back(pair_row(SAMPLE_MIN, SAMPLE_MIN));
    directed_rows.push_back(pair_row(24'sd5000000, 24'sd1000000));
    directed_rows.push_back(pair_row(-24'sd7, 24'sd3));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_WRITE: begin
          settle_idle();
          write_reg(row.idx, row.data);
        end
        ROW_KNOWN: send_pair(row.l, row.r, 1'b1, row.want);
        default:   send_pair(row.l, row.r, 1'b0, row.want);
      endcase
    end

    // Random phases: a register setting each, then a stream of decaying transients.
    amp = 1 << 20;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          fa = COEFF_MAX; fr = COEFF_MAX; sa = COEFF_MAX; sr = COEFF_MAX;
          sm = COEFF_MAX; se = COEFF_ZERO;
        end
        1: begin
          fa = COEFF_ZERO; fr = COEFF_ZERO; sa = COEFF_ZERO; sr = COEFF_ZERO;
          sm = COEFF_ZERO; se = COEFF_MAX;
        end
        3: begin
          fa = COEFF_ZERO; fr = COEFF_ZERO; sa = COEFF_MAX; sr = COEFF_MAX;
          sm = COEFF_ZERO; se = COEFF_MAX;
        end
        5, 7: begin
          fa = CW'($urandom()); fr = CW'($urandom()); sa = CW'($urandom());
          sr = CW'($urandom()); sm = CW'($urandom()); se = CW'($urandom());
        end
        default: begin
          fa = CW'($urandom_range(0, 16384));
          fr = CW'($urandom_range(32768, 65535));
          sa = CW'($urandom_range(57344, 65535));
          sr = CW'($urandom_range(60000, 65535));
          sm = CW'($urandom_range(0, 65535));
          se = CW'($urandom_range(0, 65535));
        end
      endcase
      load_setting(fa, fr, sa, sr, sm, se);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 63) == 0) begin
          steady = !steady;
        end
        if ($urandom_range(0, 15) == 0) begin
          amp = int'($urandom_range(1, 8388607));
        end else begin
          amp = (amp > 16) ? amp - amp / 16 : 16;
        end
        l = draw_sample(amp);
        r = draw_sample(amp);
        send_pair(l, r, 1'b0, '0);
      end
    end

    settle_idle();
    $display("Checked %0d results from %0d stereo requests, %0d register writes over %0d phases.",
             results_checked, pairs_sent, reg_writes, PHASES);
    $display("Gain at full scale %0d times, at zero %0d times, in between %0d times.",
             gain_full, gain_zero, results_checked - gain_full - gain_zero);
    if (mismatches == 0) begin
      $display("PASS dual_envelope_transient_splitter_top");
    end else begin
      $display("FAIL dual_envelope_transient_splitter_top");
    end
    $finish;
  end

endmodule
